// ===== hw/rtl/sha384_pkg.sv =====
package sha384_pkg;

  localparam int unsigned WordW        = 64;
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned ChainWords   = 8;
  localparam int unsigned NumRounds    = 80;
  localparam int unsigned DigestWords  = 6;
  localparam int unsigned WordIdxW     = $clog2(BlockWords);
  localparam int unsigned RoundIdxW    = $clog2(NumRounds);
  localparam int unsigned DigestCntW   = $clog2(DigestWords + 1);

  localparam logic [WordW-1:0] InitHash [ChainWords] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
    64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
    64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam logic [WordW-1:0] RoundK [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef struct packed {
    logic [WordW-1:0] msg_word;
    logic             new_message;
    logic             final_block;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             digest_last;
  } out_beat_t;

  // controller to datapath commands
  typedef struct packed {
    logic                 load_word;
    logic                 iv_reload;
    logic                 init;
    logic                 round;
    logic                 finish;
    logic                 load_digest;
    logic                 shift_digest;
    logic [RoundIdxW-1:0] round_idx;
  } dp_cmd_t;

  function automatic logic [WordW-1:0] rotr(logic [WordW-1:0] x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // round constant, zero past the last round
  function automatic logic [WordW-1:0] round_k(logic [RoundIdxW-1:0] idx);
    if (32'(idx) < NumRounds) begin
      round_k = RoundK[idx];
    end else begin
      round_k = '0;
    end
  endfunction

endpackage

// ===== hw/rtl/sha384_ctrl.sv =====
module sha384_ctrl
  import sha384_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_new_message_i,
  input  logic      in_final_block_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output logic      out_last_o,
  input  logic      out_stall_i,
  output dp_cmd_t   cmd_o
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StInit  = 2'd1;
  localparam logic [1:0] StRound = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  localparam logic [WordIdxW-1:0]   LastWord  = WordIdxW'(BlockWords - 1);
  localparam logic [RoundIdxW-1:0]  LastRound = RoundIdxW'(NumRounds - 1);
  localparam logic [DigestCntW-1:0] FullCnt   = DigestCntW'(DigestWords);

  logic [1:0]            state_q, state_d;
  logic [WordIdxW-1:0]   word_idx_q, word_idx_d;
  logic [RoundIdxW-1:0]  round_q, round_d;
  logic                  final_q, final_d;
  logic [DigestCntW-1:0] out_cnt_q, out_cnt_d;
  logic                  in_acc, out_acc;

  assign in_stall_o  = (state_q != StLoad);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (out_cnt_q != '0);
  assign out_last_o  = (out_cnt_q == DigestCntW'(1));
  assign out_acc     = out_valid_o && !out_stall_i;

  // sequencer: word loading, round iteration, chaining add, digest hand-off
  always_comb begin
    state_d    = state_q;
    word_idx_d = word_idx_q;
    round_d    = round_q;
    final_d    = final_q;
    out_cnt_d  = out_cnt_q;
    cmd_o      = '0;
    cmd_o.round_idx = round_q;

    if (out_acc) begin
      cmd_o.shift_digest = 1'b1;
      out_cnt_d = out_cnt_q - DigestCntW'(1);
    end

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          cmd_o.load_word = 1'b1;
          cmd_o.iv_reload = in_new_message_i;
          final_d    = in_final_block_i;
          word_idx_d = word_idx_q + WordIdxW'(1);
          if (word_idx_q == LastWord) begin
            state_d = StInit;
          end
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        round_d    = '0;
        state_d    = StRound;
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (round_q == LastRound) begin
          round_d = '0;
          state_d = StDone;
        end else begin
          round_d = round_q + RoundIdxW'(1);
        end
      end
      StDone: begin
        // a final block waits until the previous digest has drained
        if (!final_q) begin
          cmd_o.finish = 1'b1;
          state_d = StLoad;
        end else if (out_cnt_q == '0) begin
          cmd_o.finish      = 1'b1;
          cmd_o.load_digest = 1'b1;
          out_cnt_d = FullCnt;
          state_d   = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      word_idx_q <= '0;
      round_q    <= '0;
      final_q    <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      word_idx_q <= word_idx_d;
      round_q    <= round_d;
      final_q    <= final_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  // digest count stays within the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_cnt_q <= FullCnt)
    else $error("digest count overflow");

  // the digest buffer is only refilled once drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_digest |-> (out_cnt_q == '0))
    else $error("digest overwritten before delivery");

  // the last round hands over to the chaining add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && round_q == LastRound) |=> (state_q == StDone))
    else $error("round sequence did not end");

  // block alignment: compression only runs on a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (word_idx_q == '0))
    else $error("compression started mid-block");

endmodule

// ===== hw/rtl/sha384_dp.sv =====
module sha384_dp
  import sha384_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [WordW-1:0] msg_word_i,
  output logic [WordW-1:0] digest_word_o
);

  logic [WordW-1:0] chain_q [ChainWords];
  logic [WordW-1:0] work_q  [ChainWords];
  logic [WordW-1:0] win_q   [BlockWords];
  logic [WordW-1:0] dig_q   [DigestWords];
  logic [WordW-1:0] hkw_q, hkw_d;
  logic [WordW-1:0] sched_new, win_in;
  logic [WordW-1:0] t1, t2, ch, maj;
  logic [RoundIdxW-1:0] next_idx;

  // schedule expansion for the word sixteen rounds ahead
  assign sched_new = win_q[0] + small_sigma0(win_q[1]) + win_q[9]
                   + small_sigma1(win_q[14]);
  assign win_in    = cmd_i.load_word ? msg_word_i : sched_new;

  // round function; h + k + w comes precomputed from the previous cycle
  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
             ^ (work_q[1] & work_q[2]);
  assign t1  = hkw_q + big_sigma1(work_q[4]) + ch;
  assign t2  = big_sigma0(work_q[0]) + maj;

  // h + k + w for the next round: h is today's g, w sits next in the window
  assign next_idx = cmd_i.round_idx + RoundIdxW'(1);
  always_comb begin
    if (cmd_i.init) begin
      hkw_d = chain_q[7] + round_k('0) + win_q[0];
    end else begin
      hkw_d = work_q[6] + round_k(next_idx) + win_q[1];
    end
  end

  // chaining value, reset to the initial hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= InitHash[i];
      end
    end else if (cmd_i.iv_reload) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= InitHash[i];
      end
    end else if (cmd_i.finish) begin
      for (int i = 0; i < ChainWords; i++) begin
        chain_q[i] <= chain_q[i] + work_q[i];
      end
    end
  end

  // working variables a..h
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ChainWords; i++) begin
        work_q[i] <= '0;
      end
    end else if (cmd_i.init) begin
      for (int i = 0; i < ChainWords; i++) begin
        work_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  // message window as a shift line, oldest word at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word || cmd_i.round) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[BlockWords - 1] <= win_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.round) begin
      hkw_q <= hkw_d;
    end
  end

  // digest buffer, head word goes out first
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_digest) begin
      for (int i = 0; i < DigestWords; i++) begin
        dig_q[i] <= chain_q[i] + work_q[i];
      end
    end else if (cmd_i.shift_digest) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        dig_q[i] <= dig_q[i + 1];
      end
    end
  end

  assign digest_word_o = dig_q[0];

endmodule

// ===== hw/rtl/sha384_compression_core_unit.sv =====
// SHA-384 compression core.
// Input channel: one beat per 64-bit message word (in_i.msg_word), sixteen beats
// per padded block. in_i.new_message on any beat reloads the chaining value
// with the SHA-384 initial values; in_i.final_block on the sixteenth beat marks
// the block as the last of its message.
// Output channel: after a final block, six beats of 64-bit digest words, most
// significant first, out_o.digest_last set on the sixth.
// Timing: the sixteen words of a block are taken one per cycle. After the
// sixteenth, the input stalls through the setup state, 80 rounds at one
// round per cycle in the shared round unit, and the chaining add. The first
// digest beat is valid in the cycle after the chaining add.
// Stalls: the digest sits in its own six-word buffer, so the next message can
// be loaded while it drains. Only a further final block waits at its chaining
// add until the buffer is empty.
// Reset: the chaining value returns to the initial hash, counters clear, any
// pending digest is dropped and the input is ready at once.
module sha384_compression_core_unit
  import sha384_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_o
);

  dp_cmd_t          cmd;
  logic             out_last;
  logic [WordW-1:0] digest_word;

  // sequencer
  sha384_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_new_message_i (in_i.new_message),
    .in_final_block_i (in_i.final_block),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_last_o       (out_last),
    .out_stall_i      (out_stall_i),
    .cmd_o            (cmd)
  );

  // hash datapath
  sha384_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (in_i.msg_word),
    .digest_word_o (digest_word)
  );

  assign out_o.digest_word = digest_word;
  assign out_o.digest_last = out_last;

endmodule

// ===== test/sha384_compression_core_unit_test.sv =====
module sha384_compression_core_unit_test
  import sha384_pkg::*;
();

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned HoldOffCycles = 700;
  localparam int unsigned DrainCycles   = 120;

  localparam logic [63:0] Sha384Iv [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
    64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
    64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam logic [63:0] RoundConst [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_o;

  // stimulus and expectation stores
  in_beat_t  msg_word_q [$];
  out_beat_t digest_q [$];

  // shadow hash state
  logic [63:0] chain_h [8];
  logic [63:0] sched_w [16];
  logic [3:0]  word_pos;
  logic        last_final;

  // traffic shaping, written only with nonblocking assignments
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_ack      = 0;
  int unsigned hold_left     = 0;

  // bookkeeping
  int unsigned queued_words  = 0;
  int unsigned taken_words   = 0;
  int unsigned blocks_done   = 0;
  int unsigned digest_beats  = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned error_count   = 0;

  sha384_compression_core_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one 80-round pass over the current schedule, folded into the chain
  function automatic void sha_compress();
    logic [63:0] v [8];
    logic [63:0] w15, w2, t1, t2;
    for (int j = 0; j < 8; j++) v[j] = chain_h[j];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w15 = sched_w[(r - 15) & 15];
        w2  = sched_w[(r - 2) & 15];
        sched_w[r & 15] = sched_w[r & 15]
                        + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7))
                        + sched_w[(r - 7) & 15]
                        + (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6));
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + sched_w[r & 15];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
  endfunction

  // take one accepted message word, queue the digest when a final block ends
  function automatic void sha_absorb_word(input in_beat_t b);
    out_beat_t d;
    if (b.new_message) begin
      for (int j = 0; j < 8; j++) chain_h[j] = Sha384Iv[j];
    end
    last_final        = b.final_block;
    sched_w[word_pos] = b.msg_word;
    word_pos          = word_pos + 4'd1;
    if (word_pos == 4'd0) begin
      sha_compress();
      blocks_done++;
      if (last_final) begin
        for (int k = 0; k < DigestWords; k++) begin
          d.digest_word = chain_h[k];
          d.digest_last = (k == DigestWords - 1);
          digest_q.push_back(d);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_digest_beat(input out_beat_t got);
    out_beat_t want;
    if (digest_q.size() == 0) begin
      report_mismatch($sformatf("unexpected digest beat %h", got.digest_word));
    end else begin
      want = digest_q.pop_front();
      if (got.digest_word !== want.digest_word) begin
        report_mismatch($sformatf("digest_word %h, want %h",
                                  got.digest_word, want.digest_word));
      end
      if (got.digest_last !== want.digest_last) begin
        report_mismatch($sformatf("digest_last %b, want %b on word %h",
                                  got.digest_last, want.digest_last, want.digest_word));
      end
      digest_beats++;
    end
  endtask

  // mostly random words, with the all-zero and all-one extremes now and then
  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_block(input bit reload, input bit is_final);
    in_beat_t b;
    for (int i = 0; i < BlockWords; i++) begin
      b.msg_word    = pick_word();
      b.new_message = (i == 0) ? reload : ($urandom_range(99) < 3);
      b.final_block = (i == BlockWords - 1) ? is_final : ($urandom_range(99) < 10);
      msg_word_q.push_back(b);
      queued_words++;
    end
  endfunction

  // whole messages, now and then one that never closes or skips its reload
  function automatic void queue_messages(input int nblocks);
    int done, len;
    bit reload, broken;
    done = 0;
    while (done < nblocks) begin
      len    = ($urandom_range(5) == 0) ? 3 : (($urandom_range(2) == 0) ? 2 : 1);
      reload = ($urandom_range(9) != 0);
      broken = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        queue_block(reload && (k == 0), (k == len - 1) && !broken);
      end
      done += len;
    end
  endfunction

  // corner-case block: extremes, early final flags, reload in mid-block
  function automatic void queue_directed_block();
    in_beat_t b;
    for (int i = 0; i < BlockWords; i++) begin
      case (i)
        0:       b.msg_word = '0;
        1:       b.msg_word = '1;
        2:       b.msg_word = 64'h8000_0000_0000_0000;
        3:       b.msg_word = 64'h0000_0000_0000_0001;
        4:       b.msg_word = 64'h5555_5555_5555_5555;
        5:       b.msg_word = 64'haaaa_aaaa_aaaa_aaaa;
        default: b.msg_word = {$urandom, $urandom};
      endcase
      b.new_message = (i == 0) || (i == 7);
      b.final_block = (i == 3) || (i == 9) || (i == BlockWords - 1);
      msg_word_q.push_back(b);
      queued_words++;
    end
  endfunction

  // driver: next word goes out once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (msg_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_i       <= msg_word_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_ack    <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldOffCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sha_absorb_word(in_i);
        taken_words <= taken_words + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        check_digest_beat(out_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // sequence of traffic phases
  initial begin
    for (int j = 0; j < 8; j++) chain_h[j] = Sha384Iv[j];
    for (int j = 0; j < 16; j++) sched_w[j] = '0;
    word_pos   = '0;
    last_final = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no idling: corner block, chaining without reload, a two-block message, a random one
    queue_directed_block();
    queue_block(1'b0, 1'b1);
    queue_block(1'b1, 1'b0);
    queue_block(1'b0, 1'b1);
    queue_messages(1);
    while (taken_words != queued_words) @(posedge clk_i);

    // sender mostly idle
    send_idle_pct <= 81;
    queue_messages(1);
    while (taken_words != queued_words) @(posedge clk_i);

    // receiver mostly stalling
    send_idle_pct <= 0;
    stall_pct     <= 81;
    queue_messages(1);
    while (taken_words != queued_words) @(posedge clk_i);

    // both sides idling
    send_idle_pct <= 34;
    stall_pct     <= 34;
    queue_messages(1);
    while (taken_words != queued_words) @(posedge clk_i);

    // long receiver hold-off against back-to-back final blocks
    send_idle_pct <= 0;
    stall_pct     <= 0;
    hold_req      <= hold_req + 1;
    for (int m = 0; m < 3; m++) queue_block(1'b1, 1'b1);
    while (taken_words != queued_words) @(posedge clk_i);

    // drain
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d message words in %0d blocks, %0d digest beats checked",
             taken_words, blocks_done, digest_beats);
    $display("summary: idle, sender gaps, receiver stalls, mixed and long hold-off, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
